FILE: rtl/mdexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdexp_pkg
// Shared widths, state codes and the request/response types of the
// modular multiplier.
// ----------------------------------------------------------------------------
package mdexp_pkg;

  localparam int unsigned WIDTH   = 64;             // datapath width, 8..64
  localparam int unsigned FIELD_W = 64;             // width of every port field
  localparam int unsigned CNT_W   = $clog2(WIDTH);  // holds 0..WIDTH-1

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_RED,
    ST_SQ,
    ST_MUL,
    ST_DONE
  } mdexp_state_e;

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] x;
    logic [WIDTH-1:0] y;
    logic [WIDTH-1:0] m;
  } mdexp_mul_req_t;

  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] res;
  } mdexp_mul_rsp_t;

endpackage

FILE: rtl/mdexp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdexp_in_if / mdexp_out_if
// Valid/ready channels for the request and the result.
// ----------------------------------------------------------------------------
interface mdexp_in_if;
  logic                            valid;
  logic                            ready;
  logic [mdexp_pkg::FIELD_W-1:0] base;
  logic [mdexp_pkg::FIELD_W-1:0] modulus;
  logic [mdexp_pkg::FIELD_W-1:0] exponent;

  modport source (output valid, output base, output modulus, output exponent, input ready);
  modport sink   (input valid, input base, input modulus, input exponent, output ready);
endinterface

interface mdexp_out_if;
  logic                            valid;
  logic                            ready;
  logic [mdexp_pkg::FIELD_W-1:0] power_mod;
  logic                            modulus_zero;

  modport source (output valid, output power_mod, output modulus_zero, input ready);
  modport sink   (input valid, input power_mod, input modulus_zero, output ready);
endinterface

FILE: rtl/mdexp_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdexp_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first,
// doubling and conditional add folded into one reduction against m and 2m.
// ----------------------------------------------------------------------------
module mdexp_mulmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mdexp_pkg::mdexp_mul_req_t req_i,
  output mdexp_pkg::mdexp_mul_rsp_t rsp_o
);
  import mdexp_pkg::*;

  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] x_q, y_q, m_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] mod1;
  logic [WIDTH+1:0] mod2;
  logic [WIDTH+1:0] sub1;
  logic [WIDTH+1:0] sub2;
  logic [WIDTH-1:0] step;

  // 2*acc + bit*x stays below 3m, so one subtract of m or 2m reduces it
  always_comb begin
    sum  = {1'b0, acc_q, 1'b0} + (y_q[WIDTH-1] ? {2'b00, x_q} : '0);
    mod1 = {2'b00, m_q};
    mod2 = {1'b0, m_q, 1'b0};
    sub1 = sum - mod1;
    sub2 = sum - mod2;
    priority if (sum >= mod2) begin
      step = sub2[WIDTH-1:0];
    end else if (sum >= mod1) begin
      step = sub1[WIDTH-1:0];
    end else begin
      step = sum[WIDTH-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WIDTH - 1);
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = step;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (req_i.start) begin
      x_q <= req_i.x;
      y_q <= req_i.y;
      m_q <= req_i.m;
    end else if (busy_q) begin
      y_q <= {y_q[WIDTH-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

endmodule

FILE: rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// Left-to-right square-and-multiply modular exponentiation on a bit-serial
// modular multiplier.
// ----------------------------------------------------------------------------
// Zero modulus, modulus one or exponent zero go straight from the request to
// the done state. Otherwise the controller scans for the top exponent bit t,
// reduces the base on the multiplier, runs a squaring for each bit below t and
// a multiply for each set bit below t, and loads the result register once the
// output is free. One request is worked on at a time; the multiplier sets the
// rate. Reset clears the controller and result valid.
module modular_exponentiation (
  input  logic         clk_i,
  input  logic         rst_ni,
  mdexp_in_if.sink     req_i,
  mdexp_out_if.source  rsp_o
);
  import mdexp_pkg::*;

  mdexp_state_e state_q, state_d;

  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] mod_q, mod_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             err_q, err_d;
  logic             launched_q, launched_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] out_val_q;
  logic             out_err_q;

  logic [WIDTH-1:0] in_base, in_mod, in_exp;
  logic             accept;
  logic             out_free;
  logic             trivial;

  mdexp_mul_req_t mul_req;
  mdexp_mul_rsp_t mul_rsp;

  assign in_base  = req_i.base[WIDTH-1:0];
  assign in_mod   = req_i.modulus[WIDTH-1:0];
  assign in_exp   = req_i.exponent[WIDTH-1:0];
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign trivial  = (in_mod == '0) || (in_mod == WIDTH'(1)) || (in_exp == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = trivial ? ST_DONE : ST_NORM;
      end
      ST_NORM: begin
        if (exp_q[WIDTH-1]) state_d = ST_RED;
      end
      ST_RED: begin
        if (mul_rsp.done) state_d = (rem_q == '0) ? ST_DONE : ST_SQ;
      end
      ST_SQ: begin
        if (mul_rsp.done) begin
          priority if (exp_q[WIDTH-1]) state_d = ST_MUL;
          else if (rem_q == CNT_W'(1)) state_d = ST_DONE;
          else state_d = ST_SQ;
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) state_d = (rem_q == CNT_W'(1)) ? ST_DONE : ST_SQ;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    base_d      = base_q;
    mod_d       = mod_q;
    exp_d       = exp_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    err_d       = err_q;
    launched_d  = launched_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    req_i.ready = 1'b0;
    mul_req.start = 1'b0;
    mul_req.x     = acc_q;
    mul_req.y     = acc_q;
    mul_req.m     = mod_q;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (accept) begin
          base_d = in_base;
          mod_d  = in_mod;
          exp_d  = in_exp;
          rem_d  = CNT_W'(WIDTH - 1);
          err_d  = (in_mod == '0);
          acc_d  = (in_mod != '0 && in_mod != WIDTH'(1)) ? WIDTH'(1) : '0;
        end
      end
      ST_NORM: begin
        // shift up to the top set bit, then drop it
        exp_d = {exp_q[WIDTH-2:0], 1'b0};
        if (!exp_q[WIDTH-1]) rem_d = rem_q - CNT_W'(1);
      end
      ST_RED: begin
        mul_req.start = !launched_q;
        mul_req.x     = WIDTH'(1);
        mul_req.y     = base_q;
        if (!launched_q) launched_d = 1'b1;
        if (mul_rsp.done) begin
          launched_d = 1'b0;
          base_d     = mul_rsp.res;
          acc_d      = mul_rsp.res;
        end
      end
      ST_SQ: begin
        mul_req.start = !launched_q;
        if (!launched_q) launched_d = 1'b1;
        if (mul_rsp.done) begin
          launched_d = 1'b0;
          acc_d      = mul_rsp.res;
          if (!exp_q[WIDTH-1]) begin
            exp_d = {exp_q[WIDTH-2:0], 1'b0};
            rem_d = rem_q - CNT_W'(1);
          end
        end
      end
      ST_MUL: begin
        mul_req.start = !launched_q;
        mul_req.y     = base_q;
        if (!launched_q) launched_d = 1'b1;
        if (mul_rsp.done) begin
          launched_d = 1'b0;
          acc_d      = mul_rsp.res;
          exp_d      = {exp_q[WIDTH-2:0], 1'b0};
          rem_d      = rem_q - CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launched_q  <= launched_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    mod_q  <= mod_d;
    exp_q  <= exp_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    err_q  <= err_d;
    if (state_q == ST_DONE && out_free) begin
      out_val_q <= acc_q;
      out_err_q <= err_q;
    end
  end

  mdexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.power_mod    = FIELD_W'(out_val_q);
  assign rsp_o.modulus_zero = out_err_q;

endmodule

FILE: rtl/mdexp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdexp_checker
// Port-level checks on the request and result channels of the block.
// ----------------------------------------------------------------------------
module mdexp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [mdexp_pkg::FIELD_W-1:0] out_power_mod_i,
  input logic                            out_modulus_zero_i
);
  import mdexp_pkg::*;

  // a held result stays valid, with power_mod unchanged, until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_power_mod_i))
    else $error("result dropped or changed while stalled");

  // an error result carries zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_modulus_zero_i |-> out_power_mod_i == '0)
    else $error("modulus zero result is not zero");

  // one request in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in work");

  // a new result only follows a request in work
  a_rsp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared with no request in work");

endmodule

bind modular_exponentiation mdexp_checker u_mdexp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (req_i.valid),
  .in_ready_i         (req_i.ready),
  .out_valid_i        (rsp_o.valid),
  .out_ready_i        (rsp_o.ready),
  .out_power_mod_i    (rsp_o.power_mod),
  .out_modulus_zero_i (rsp_o.modulus_zero)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for modular_exponentiation: directed corner requests,
// an unbroken back-to-back stretch and random requests with random gaps and
// result stalls, each result compared against an in-bench power predictor.
// ----------------------------------------------------------------------------
module tb;
  import mdexp_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] power_mod;
    logic               modulus_zero;
  } power_result_t;

  logic clk_i;
  logic rst_ni;

  mdexp_in_if  req_if ();
  mdexp_out_if rsp_if ();

  modular_exponentiation u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  power_result_t pending_powers[$];
  int unsigned   n_requests;
  int unsigned   n_checked = 0;
  int unsigned   n_zero_modulus;
  int unsigned   n_wide_exponents;
  int unsigned   n_errors = 0;
  bit            steady_flow;
  int unsigned   rsp_stall_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // (x * y) mod m on a double-width product
  function automatic logic [WIDTH-1:0] product_mod(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y,
                                                   logic [WIDTH-1:0] m);
    logic [2*WIDTH-1:0] prod;
    prod = {{WIDTH{1'b0}}, x} * {{WIDTH{1'b0}}, y};
    return WIDTH'(prod % {{WIDTH{1'b0}}, m});
  endfunction

  function automatic power_result_t predict_power(logic [FIELD_W-1:0] base,
                                                  logic [FIELD_W-1:0] modulus,
                                                  logic [FIELD_W-1:0] exponent);
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] m;
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] acc;
    int               top;
    power_result_t    r;
    b = base[WIDTH-1:0];
    m = modulus[WIDTH-1:0];
    e = exponent[WIDTH-1:0];
    r = '0;
    if (m == '0) begin
      r.modulus_zero = 1'b1;
      return r;
    end
    b = b % m;
    if (e == '0) begin
      r.power_mod = (m == WIDTH'(1)) ? '0 : FIELD_W'(1);
      return r;
    end
    top = 0;
    for (int i = 0; i < WIDTH; i++)
      if (e[i]) top = i;
    acc = b;
    for (int i = top - 1; i >= 0; i--) begin
      acc = product_mod(acc, acc, m);
      if (e[i]) acc = product_mod(acc, b, m);
    end
    r.power_mod = FIELD_W'(acc);
    return r;
  endfunction

  // Hold valid across back-to-back requests; only drop it for a gap
  task automatic send_request(logic [FIELD_W-1:0] base, logic [FIELD_W-1:0] modulus,
                              logic [FIELD_W-1:0] exponent);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.base     <= base;
    req_if.modulus  <= modulus;
    req_if.exponent <= exponent;
    do @(posedge clk_i); while (!req_if.ready);
    pending_powers.push_back(predict_power(base, modulus, exponent));
    n_requests++;
    if (modulus[WIDTH-1:0] == '0) n_zero_modulus++;
    if (exponent[WIDTH-1]) n_wide_exponents++;
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  // Result sink: random stall after each result, compare with oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready   <= 1'b0;
      rsp_stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_powers.size() == 0) begin
          $error("unexpected result: power_mod=%h modulus_zero=%b",
                 rsp_if.power_mod, rsp_if.modulus_zero);
          n_errors++;
        end else begin
          power_result_t want;
          want = pending_powers.pop_front();
          n_checked++;
          if (rsp_if.power_mod !== want.power_mod) begin
            $error("power_mod: expected %h, got %h", want.power_mod, rsp_if.power_mod);
            n_errors++;
          end
          if (rsp_if.modulus_zero !== want.modulus_zero) begin
            $error("modulus_zero: expected %b, got %b", want.modulus_zero,
                   rsp_if.modulus_zero);
            n_errors++;
          end
        end
        rsp_stall_left = steady_flow ? 0 : $urandom_range(0, 5);
        if (rsp_stall_left > 0) rsp_if.ready <= 1'b0;
      end else if (!rsp_if.ready) begin
        if (rsp_stall_left > 1) rsp_stall_left--;
        else rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic test_corner_requests();
    localparam logic [FIELD_W-1:0] ONES = '1;
    send_request(64'd5, 64'd0, 64'd3);
    send_request(ONES, 64'd0, ONES);
    send_request(64'd0, 64'd0, 64'd0);
    send_request(64'd123, 64'd1, 64'd0);
    send_request(ONES, 64'd1, ONES);
    send_request(64'd0, 64'd97, 64'd0);
    send_request(ONES, ONES, 64'd0);
    send_request(ONES, 64'd1000003, 64'd1);
    send_request(64'd0, 64'd97, 64'd5);
    send_request(64'd3, 64'd7, 64'd4);
    send_request(64'd2, 64'd13, 64'd12);
    send_request(64'd4, 64'd497, 64'd13);
    send_request(64'd100, 64'd7, 64'd3);
    send_request(ONES - 64'd1, ONES, 64'd2);
    send_request(64'h8000_0000_0000_0001, ONES, ONES);
    send_request(64'd2, 64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC4);
    send_request(64'hDEAD_BEEF_0BAD_F00D, 64'h8000_0000_0000_0000, 64'h1234_5678_9ABC_DEF0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    for (int i = 0; i < 12; i++)
      send_request({$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(0, 255)));
    wait_for_results();
    steady_flow = 1'b0;
  endtask

  task automatic test_random_requests(int unsigned count);
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] m;
    logic [FIELD_W-1:0] e;
    int unsigned        len;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      b = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) b = 64'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0:       m = 64'($urandom_range(0, 1));
        1, 2:    m = 64'($urandom_range(2, 1000));
        default: m = {$urandom, $urandom};
      endcase
      // keep most exponents short, the scan length sets the run time
      if ($urandom_range(0, 6) == 0) begin
        e = {$urandom, $urandom};
      end else begin
        len = $urandom_range(0, 20);
        e = {$urandom, $urandom} & ((64'd1 << len) - 64'd1);
      end
      send_request(b, m, e);
    end
    wait_for_results();
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    steady_flow     = 1'b0;
    n_requests      = 0;
    n_zero_modulus  = 0;
    n_wide_exponents = 0;
    req_if.valid    <= 1'b0;
    req_if.base     <= '0;
    req_if.modulus  <= '0;
    req_if.exponent <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_requests();
    test_back_to_back();
    test_random_requests(80);

    req_if.valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Checked %0d results from %0d requests (%0d zero modulus, %0d full-width exponents),",
             n_checked, n_requests, n_zero_modulus, n_wide_exponents);
    $display("with random request gaps and result stalls plus one unbroken stretch.");
    if (n_errors == 0 && pending_powers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Give up if the run has not finished well past its worst case
  initial begin
    #(50_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mdexp_pkg.sv
rtl/mdexp_if.sv
rtl/mdexp_mulmod.sv
rtl/modular_exponentiation.sv
rtl/mdexp_checker.sv
tb/sv/tb.sv
